@@ design/c2re_pkg.sv @@
// c2re_pkg: shared types and constants for conv2d_replicate_edge.
// No dependencies.
package c2re_pkg;

	localparam int FRAC_BITS = 12;
	localparam int ACC_BITS  = 40;

	typedef enum logic [1:0] {
		CMD_WEIGHT  = 2'd0,
		CMD_BIAS    = 2'd1,
		CMD_PIXEL   = 2'd2,
		CMD_COMPUTE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_IN_CH   = 3'd0,
		REG_ROWS    = 3'd1,
		REG_COLS    = 3'd2,
		REG_OUT_CH  = 3'd3,
		REG_KERNEL  = 3'd4,
		REG_PADDING = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_OUT
	} state_t;

endpackage

@@ design/c2re_round.sv @@
// c2re_round: rounds a Q28.12 accumulator to the output format with saturation.
// Depends on c2re_pkg.
module c2re_round
	import c2re_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic signed [ACC_BITS-1:0] acc,
	output logic        [15:0]         res,
	output logic                       sat
);

	localparam int QW = ACC_BITS - FRAC_BITS + 1;

	logic signed [ACC_BITS:0] r;
	logic signed [QW-1:0]     q;
	logic signed [QW-1:0]     hi;
	logic signed [QW-1:0]     lo;
	logic signed [QW-1:0]     qs;

	always_comb begin
		r  = {acc[ACC_BITS-1], acc} + (ACC_BITS+1)'(1 << (FRAC_BITS - 1));
		q  = r[ACC_BITS:FRAC_BITS];
		hi = QW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
		lo = -hi - QW'(1);
		sat = 1'b0;
		qs = q;
		if (q > hi) begin
			qs = hi;
			sat = 1'b1;
		end else if (q < lo) begin
			qs = lo;
			sat = 1'b1;
		end
		res = qs[15:0];
	end

endmodule

@@ design/conv2d_replicate_edge.sv @@
// conv2d_replicate_edge: multi-channel 2D convolution, one output per request.
// Depends on c2re_pkg and c2re_round.
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | cmd out_chan in_chan row_pos col_pos value
// out     | out_valid/ out_ready | out_value saturated bad_request
// cfg     | cfg_we               | cfg_index cfg_data
//
// A compute performs one MAC per cycle, bound by the single read port of each
// store; a bad request skips the MAC loop and goes straight to the result.
// Reset clears control and registers only; stores are undefined until written.
// in_ready is low while a compute runs or its result waits for out_ready.
module conv2d_replicate_edge
	import c2re_pkg::*;
#(
	parameter int MAX_IN_CHANNELS  = 4,
	parameter int MAX_OUT_CHANNELS = 8,
	parameter int MAX_ROWS         = 32,
	parameter int MAX_COLS         = 32,
	parameter int MAX_KERNEL       = 5,
	parameter int DATA_WIDTH       = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [2:0]         out_chan,
	input  logic [1:0]         in_chan,
	input  logic [4:0]         row_pos,
	input  logic [4:0]         col_pos,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_value,
	output logic               saturated,
	output logic               bad_request
);

	localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
	localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAPS;
	localparam int IDEPTH = MAX_IN_CHANNELS * MAX_ROWS * MAX_COLS;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int IAW    = $clog2(IDEPTH);
	localparam int OCW    = $clog2(MAX_OUT_CHANNELS);
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int CW     = $clog2(MAX_COLS + 1);
	localparam int SW     = 10;

	logic signed [DATA_WIDTH-1:0] weight_mem [WDEPTH];
	logic signed [DATA_WIDTH-1:0] bias_mem   [MAX_OUT_CHANNELS];
	logic signed [DATA_WIDTH-1:0] image_mem  [IDEPTH];

	logic [2:0] nic_q;
	logic [5:0] rows_q, cols_q;
	logic [3:0] noc_q;
	logic [2:0] k_q;
	logic       pad_q;

	state_t state_q, state_d;

	logic [2:0]  oc_q;
	logic [4:0]  orow_q, ocol_q;
	logic [2:0]  c_q;
	logic [2:0]  tr_q, tc_q;
	logic        rd_v_s1, rd_v_s2;
	logic signed [DATA_WIDTH-1:0] w_s1, p_s1, b_s1;
	logic signed [2*DATA_WIDTH-1:0] prod_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic [15:0] res_q;
	logic        sat_q, bad_q;
	logic [15:0] rnd_res;
	logic        rnd_sat;

	// clamped configuration
	logic [5:0] nic, rows, cols, noc, k;
	always_comb begin
		nic  = (nic_q == 3'd0) ? 6'd1 : (32'(nic_q) > MAX_IN_CHANNELS ? 6'(MAX_IN_CHANNELS) : 6'(nic_q));
		rows = (rows_q == 6'd0) ? 6'd1 : (32'(rows_q) > MAX_ROWS ? 6'(MAX_ROWS) : rows_q);
		cols = (cols_q == 6'd0) ? 6'd1 : (32'(cols_q) > MAX_COLS ? 6'(MAX_COLS) : cols_q);
		noc  = (noc_q == 4'd0) ? 6'd1 : (32'(noc_q) > MAX_OUT_CHANNELS ? 6'(MAX_OUT_CHANNELS) : 6'(noc_q));
		k    = (k_q == 3'd0) ? 6'd1 : (32'(k_q) > MAX_KERNEL ? 6'(MAX_KERNEL) : 6'(k_q));
	end

	logic signed [7:0] orows, ocols, pad;
	logic req_bad;
	always_comb begin
		pad   = pad_q ? 8'(k >> 1) : 8'sd0;
		orows = pad_q ? 8'(rows) : 8'(rows) - 8'(k) + 8'sd1;
		ocols = pad_q ? 8'(cols) : 8'(cols) - 8'(k) + 8'sd1;
		req_bad = (6'(out_chan) >= noc) || ($signed(8'(row_pos)) >= orows)
			|| ($signed(8'(col_pos)) >= ocols);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nic_q <= 3'd1; rows_q <= 6'd32; cols_q <= 6'd32;
			noc_q <= 4'd1; k_q <= 3'd3; pad_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_CH:   nic_q  <= cfg_data[2:0];
				REG_ROWS:    rows_q <= cfg_data;
				REG_COLS:    cols_q <= cfg_data;
				REG_OUT_CH:  noc_q  <= cfg_data[3:0];
				REG_KERNEL:  k_q    <= cfg_data[2:0];
				REG_PADDING: pad_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic in_xfer, out_xfer;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;

	logic signed [DATA_WIDTH-1:0] val_n;
	assign val_n = DATA_WIDTH'(value);

	// write path
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			unique case (cmd_t'(cmd))
				CMD_WEIGHT: if (32'(out_chan) < MAX_OUT_CHANNELS && 32'(in_chan) < MAX_IN_CHANNELS
						&& 32'(row_pos) < MAX_KERNEL && 32'(col_pos) < MAX_KERNEL) begin
					weight_mem[WAW'((32'(out_chan) * MAX_IN_CHANNELS + 32'(in_chan)) * TAPS
						+ 32'(row_pos) * MAX_KERNEL + 32'(col_pos))] <= val_n;
				end
				CMD_BIAS: if (32'(out_chan) < MAX_OUT_CHANNELS) begin
					bias_mem[OCW'(out_chan)] <= val_n;
				end
				CMD_PIXEL: if (32'(in_chan) < MAX_IN_CHANNELS && 32'(row_pos) < MAX_ROWS
						&& 32'(col_pos) < MAX_COLS) begin
					image_mem[IAW'((32'(in_chan) * MAX_ROWS + 32'(row_pos)) * MAX_COLS
						+ 32'(col_pos))] <= val_n;
				end
				CMD_COMPUTE: ;
				default: ;
			endcase
		end
	end

	// tap address generation
	logic signed [SW-1:0] x, y;
	logic [RW-1:0] xc;
	logic [CW-1:0] yc;
	logic last_tap;
	always_comb begin
		x = SW'(orow_q) - SW'(pad) + SW'(tr_q);
		y = SW'(ocol_q) - SW'(pad) + SW'(tc_q);
		if (x < 0) xc = '0;
		else if (x >= SW'(rows)) xc = RW'(rows - 6'd1);
		else xc = RW'(x);
		if (y < 0) yc = '0;
		else if (y >= SW'(cols)) yc = CW'(cols - 6'd1);
		else yc = CW'(y);
		last_tap = (6'(tc_q) == k - 6'd1) && (6'(tr_q) == k - 6'd1) && (6'(c_q) == nic - 6'd1);
	end

	always_ff @(posedge clk) begin
		b_s1 <= bias_mem[OCW'(oc_q)];
		w_s1 <= weight_mem[WAW'((32'(oc_q) * MAX_IN_CHANNELS + 32'(c_q)) * TAPS
			+ 32'(tr_q) * MAX_KERNEL + 32'(tc_q))];
		p_s1 <= image_mem[IAW'((32'(c_q) * MAX_ROWS + 32'(xc)) * MAX_COLS + 32'(yc))];
		prod_s2 <= w_s1 * p_s1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_xfer && cmd == CMD_COMPUTE) state_d = req_bad ? ST_OUT : ST_BIAS;
			ST_BIAS:  state_d = ST_MAC;
			ST_MAC:   if (last_tap) state_d = ST_DRAIN;
			ST_DRAIN: if (!rd_v_s1 && !rd_v_s2) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_OUT;
			ST_OUT:   if (out_xfer) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	c2re_round #(.DATA_WIDTH(DATA_WIDTH)) u_round (
		.acc(acc_q), .res(rnd_res), .sat(rnd_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == ST_MAC);
			rd_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			oc_q <= out_chan; orow_q <= row_pos; ocol_q <= col_pos;
			c_q <= '0; tr_q <= '0; tc_q <= '0;
			bad_q <= req_bad; res_q <= '0; sat_q <= 1'b0;
		end
		if (state_q == ST_MAC && !last_tap) begin
			if (6'(tc_q) == k - 6'd1) begin
				tc_q <= '0;
				if (6'(tr_q) == k - 6'd1) begin
					tr_q <= '0;
					c_q <= c_q + 3'd1;
				end else begin
					tr_q <= tr_q + 3'd1;
				end
			end else begin
				tc_q <= tc_q + 3'd1;
			end
		end
		if (state_q == ST_MAC && !rd_v_s1) begin
			acc_q <= ACC_BITS'(b_s1) <<< FRAC_BITS;
		end else if (rd_v_s2) begin
			acc_q <= acc_q + ACC_BITS'(prod_s2);
		end
		if (state_q == ST_ROUND) begin
			res_q <= rnd_res;
			sat_q <= rnd_sat;
		end
	end

	assign out_value   = res_q;
	assign saturated   = sat_q;
	assign bad_request = bad_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> !saturated && out_value == 16'd0)
		else $error("bad request with data");

endmodule

@@ bench/conv2d_replicate_edge_check.sv @@
// Scoreboard for conv2d_replicate_edge: watches the config port and both channels,
// keeps its own copy of the stores and registers and checks every result in order.
// Depends on c2re_pkg.
`timescale 1ns / 1ps

module conv2d_replicate_edge_check
	import c2re_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [2:0]         out_chan,
	input  logic [1:0]         in_chan,
	input  logic [4:0]         row_pos,
	input  logic [4:0]         col_pos,
	input  logic signed [15:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] out_value,
	input  logic               saturated,
	input  logic               bad_request,
	output int                 fail_count,
	output int                 pending,
	output int                 results_checked,
	output int                 sat_seen,
	output int                 bad_seen
);

	typedef struct {
		logic signed [15:0] val;
		logic               sat;
		logic               bad;
	} conv_result_t;

	logic signed [15:0] weight_mem [8][4][5][5];
	logic signed [15:0] bias_mem [8];
	logic signed [15:0] image_mem [4][32][32];

	logic [2:0] nic_reg;
	logic [5:0] rows_reg;
	logic [5:0] cols_reg;
	logic [3:0] noc_reg;
	logic [2:0] kern_reg;
	logic       pad_reg;

	conv_result_t expected_q[$];

	function automatic int fit(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic conv_result_t conv_output(int oc, int r, int c);
		int nic, rows, cols, noc, k, pad, orows, ocols, x, y;
		logic signed [39:0] acc;
		logic signed [31:0] prod;
		logic signed [63:0] rnd;
		conv_result_t res;
		nic = fit(nic_reg, 4);
		rows = fit(rows_reg, 32);
		cols = fit(cols_reg, 32);
		noc = fit(noc_reg, 8);
		k = fit(kern_reg, 5);
		pad = pad_reg ? k / 2 : 0;
		orows = pad_reg ? rows : rows - (k - 1);
		ocols = pad_reg ? cols : cols - (k - 1);
		res.val = '0;
		res.sat = 1'b0;
		res.bad = 1'b0;
		if (oc >= noc || r >= orows || c >= ocols) begin
			res.bad = 1'b1;
			return res;
		end
		acc = bias_mem[oc];
		acc = acc <<< FRAC_BITS;
		for (int ch = 0; ch < nic; ch++)
			for (int tr = 0; tr < k; tr++) begin
				x = r - pad + tr;
				if (x < 0) x = 0;
				else if (x >= rows) x = rows - 1;
				for (int tc = 0; tc < k; tc++) begin
					y = c - pad + tc;
					if (y < 0) y = 0;
					else if (y >= cols) y = cols - 1;
					prod = weight_mem[oc][ch][tr][tc] * image_mem[ch][x][y];
					acc = acc + prod;
				end
			end
		rnd = acc;
		rnd = (rnd + 64'sd2048) >>> FRAC_BITS;
		if (rnd > 64'sd32767) begin
			res.val = 16'sh7fff;
			res.sat = 1'b1;
		end else if (rnd < -64'sd32768) begin
			res.val = 16'sh8000;
			res.sat = 1'b1;
		end else
			res.val = rnd[15:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_result_t exp_r;
		if (!arst_n) begin
			nic_reg = 3'd1;
			rows_reg = 6'd32;
			cols_reg = 6'd32;
			noc_reg = 4'd1;
			kern_reg = 3'd3;
			pad_reg = 1'b1;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			sat_seen = 0;
			bad_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IN_CH:   nic_reg = cfg_data[2:0];
					REG_ROWS:    rows_reg = cfg_data;
					REG_COLS:    cols_reg = cfg_data;
					REG_OUT_CH:  noc_reg = cfg_data[3:0];
					REG_KERNEL:  kern_reg = cfg_data[2:0];
					REG_PADDING: pad_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected: out_value %0d", out_value);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					results_checked++;
					if (exp_r.sat) sat_seen++;
					if (exp_r.bad) bad_seen++;
					if (out_value !== exp_r.val) begin
						$error("out_value expected %0d actual %0d", exp_r.val, out_value);
						fail_count++;
					end
					if (saturated !== exp_r.sat) begin
						$error("saturated expected %0d actual %0d", exp_r.sat, saturated);
						fail_count++;
					end
					if (bad_request !== exp_r.bad) begin
						$error("bad_request expected %0d actual %0d", exp_r.bad, bad_request);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (cmd_t'(cmd))
					CMD_WEIGHT:
						if (row_pos < 5 && col_pos < 5)
							weight_mem[out_chan][in_chan][row_pos][col_pos] = value;
					CMD_BIAS:  bias_mem[out_chan] = value;
					CMD_PIXEL: image_mem[in_chan][row_pos][col_pos] = value;
					default:   expected_q.push_back(conv_output(out_chan, row_pos, col_pos));
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ bench/conv2d_replicate_edge_test.sv @@
// Stimulus and verdict for conv2d_replicate_edge: fills the stores, then runs
// directed and random phases over several register settings with random stalls.
// Depends on c2re_pkg, conv2d_replicate_edge and conv2d_replicate_edge_check.
`timescale 1ns / 1ps

module conv2d_replicate_edge_test;
	import c2re_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int CYCLE_LIMIT = 3000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [5:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [2:0]         out_chan;
	logic [1:0]         in_chan;
	logic [4:0]         row_pos;
	logic [4:0]         col_pos;
	logic signed [15:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_value;
	logic               saturated;
	logic               bad_request;

	int fail_count, pending, results_checked, sat_seen, bad_seen;
	int tx_idle, rx_idle, hold_req, cycles, sent, settings;
	int cur_rows, cur_cols, cur_k, cur_pad, cur_noc;

	conv2d_replicate_edge DUT (.*);

	conv2d_replicate_edge_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("conv2d_replicate_edge test failed");
			$finish;
		end
	end

	initial begin
		int hold_cnt;
		hold_cnt = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(8191)) - 4096);
			default: return 16'($signed($urandom_range(511)) - 256);
		endcase
	endfunction

	task automatic send(cmd_t c, int oc, int ic, int r, int col, logic signed [15:0] v);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		out_chan <= 3'(oc);
		in_chan <= 2'(ic);
		row_pos <= 5'(r);
		col_pos <= 5'(col);
		value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 6'(d);
		@(negedge clk);
	endtask

	function automatic int fit(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic configure(int nic, int rows, int cols, int noc, int k, int pad);
		drain();
		write_reg(REG_IN_CH, nic);
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		write_reg(REG_OUT_CH, noc);
		write_reg(REG_KERNEL, k);
		write_reg(REG_PADDING, pad);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_rows = fit(rows & 63, 32);
		cur_cols = fit(cols & 63, 32);
		cur_k = fit(k & 7, 5);
		cur_pad = pad & 1;
		cur_noc = fit(noc & 15, 8);
		settings++;
	endtask

	task automatic compute_any();
		int orows, ocols;
		orows = cur_pad ? cur_rows : cur_rows - cur_k + 1;
		ocols = cur_pad ? cur_cols : cur_cols - cur_k + 1;
		if ($urandom_range(9) == 0 || orows < 1 || ocols < 1)
			send(CMD_COMPUTE, $urandom_range(7), $urandom_range(3),
				$urandom_range(31), $urandom_range(31), rand_value());
		else
			send(CMD_COMPUTE, $urandom_range(cur_noc - 1), $urandom_range(3),
				$urandom_range(orows - 1), $urandom_range(ocols - 1), rand_value());
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0, 1, 2:
					send(CMD_PIXEL, $urandom_range(7), $urandom_range(3), $urandom_range(31),
						$urandom_range(31), rand_value());
				3, 4:
					send(CMD_WEIGHT, $urandom_range(7), $urandom_range(3), $urandom_range(4),
						$urandom_range(4), rand_value());
				5:
					send(CMD_WEIGHT, $urandom_range(7), $urandom_range(3), $urandom_range(31),
						$urandom_range(31), rand_value());
				6, 7:
					send(CMD_BIAS, $urandom_range(7), $urandom_range(3), $urandom_range(31),
						$urandom_range(31), rand_value());
				default: compute_any();
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_WEIGHT;
		out_chan = '0;
		in_chan = '0;
		row_pos = '0;
		col_pos = '0;
		value = '0;
		tx_idle = 0;
		rx_idle = 0;
		hold_req = 0;
		cycles = 0;
		sent = 0;
		settings = 0;
		cur_rows = 32;
		cur_cols = 32;
		cur_k = 3;
		cur_pad = 1;
		cur_noc = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every entry a compute can read gets a value: images stay within 8 by 8
		// and at most two filters are in use
		for (int oc = 0; oc < 8; oc++)
			send(CMD_BIAS, oc, 0, 0, 0, rand_value());
		for (int oc = 0; oc < 2; oc++)
			for (int ic = 0; ic < 4; ic++)
				for (int r = 0; r < 5; r++)
					for (int c = 0; c < 5; c++)
						send(CMD_WEIGHT, oc, ic, r, c, rand_value());
		for (int ic = 0; ic < 4; ic++)
			for (int r = 0; r < 8; r++)
				for (int c = 0; c < 8; c++)
					send(CMD_PIXEL, 0, ic, r, c, rand_value());

		// directed: reset settings, corners, extremes, ignored writes
		send(CMD_COMPUTE, 0, 0, 0, 0, '0);
		send(CMD_COMPUTE, 7, 0, 0, 0, '0);
		configure(1, 8, 8, 1, 3, 1);
		send(CMD_COMPUTE, 0, 3, 7, 7, 16'sh7fff);
		send(CMD_PIXEL, 0, 0, 7, 7, 16'sh8000);
		send(CMD_WEIGHT, 0, 0, 2, 2, 16'sh7fff);
		send(CMD_WEIGHT, 0, 0, 31, 31, 16'sh1234);
		send(CMD_BIAS, 0, 0, 0, 0, 16'sh7fff);
		send(CMD_COMPUTE, 0, 0, 7, 7, '0);
		send(CMD_PIXEL, 0, 0, 7, 7, 16'sh7fff);
		send(CMD_WEIGHT, 0, 0, 2, 2, 16'sh8000);
		send(CMD_COMPUTE, 0, 0, 7, 7, '0);
		send(CMD_BIAS, 0, 0, 0, 0, 16'sh8000);
		send(CMD_COMPUTE, 0, 0, 7, 7, '0);
		send(CMD_WEIGHT, 0, 0, 2, 2, 16'sh0001);
		send(CMD_BIAS, 0, 0, 0, 0, '0);
		send(CMD_COMPUTE, 0, 0, 6, 0, '0);
		configure(4, 8, 8, 2, 5, 1);
		send(CMD_COMPUTE, 1, 0, 0, 7, '0);
		send(CMD_COMPUTE, 1, 0, 7, 0, '0);
		configure(0, 0, 0, 0, 0, 0);
		send(CMD_COMPUTE, 0, 0, 0, 0, '0);
		send(CMD_COMPUTE, 1, 0, 0, 0, '0);
		drain();
		write_reg(REG_UNUSED, 6'h3f);
		cfg_we <= 1'b0;
		@(negedge clk);
		configure(7, 63, 63, 15, 7, 0);
		send(CMD_COMPUTE, 7, 0, 28, 0, '0);
		send(CMD_COMPUTE, 7, 0, 0, 28, '0);
		configure(2, 3, 3, 3, 5, 0);
		send(CMD_COMPUTE, 0, 0, 0, 0, '0);

		tx_idle = 24;
		rx_idle = 54;
		configure(4, 5, 7, 2, 5, 0);
		random_phase(60);
		configure($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8),
			$urandom_range(1, 2), $urandom_range(1, 5), 1);
		hold_req = 400;
		for (int i = 0; i < 30; i++) compute_any();
		drain();
		random_phase(50);

		tx_idle = 54;
		rx_idle = 24;
		configure(1, 8, 8, 1, 3, 1);
		random_phase(60);
		configure($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8),
			$urandom_range(1, 2), $urandom_range(1, 5), 0);
		random_phase(60);

		tx_idle = 0;
		rx_idle = 0;
		configure(3, 1, 8, 2, 4, 1);
		random_phase(60);
		configure(4, 8, 8, 2, 5, 1);
		random_phase(60);

		drain();
		repeat (150) @(negedge clk);
		$display("Summary: %0d input transfers over %0d register settings, %0d results checked",
			sent, settings, results_checked);
		$display("Summary: %0d saturated and %0d bad-request results among them",
			sat_seen, bad_seen);
		if (fail_count == 0 && pending == 0)
			$display("conv2d_replicate_edge test passed");
		else
			$display("conv2d_replicate_edge test failed");
		$finish;
	end

endmodule

@@ files.f @@
design/c2re_pkg.sv
design/c2re_round.sv
design/conv2d_replicate_edge.sv
bench/conv2d_replicate_edge_check.sv
bench/conv2d_replicate_edge_test.sv
